/* hw/rtl/rgbh_pkg.sv */
package rgbh_pkg;

  // Default width of one bin's count.
  localparam int COUNT_WIDTH_DEF = 24;

  // Histogram geometry and field widths.
  localparam int NUM_BINS  = 256;
  localparam int BIN_W     = 8;
  localparam int CHAN_W    = 8;
  localparam int HEIGHT_W  = 8;
  localparam int OUT_CNT_W = 24;
  localparam int APB_W     = 32;
  localparam int ADDR_W    = 3;

  // Command codes of an input item.
  localparam logic [1:0] CMD_ACCUM = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Bin source codes.
  localparam logic [1:0] SRC_GRAY  = 2'd0;
  localparam logic [1:0] SRC_RED   = 2'd1;
  localparam logic [1:0] SRC_GREEN = 2'd2;
  localparam logic [1:0] SRC_BLUE  = 2'd3;

  // Register select, taken from the word address bit.
  localparam logic REG_BIN_SOURCE  = 1'b0;
  localparam logic REG_PLOT_HEIGHT = 1'b1;

  localparam logic [HEIGHT_W-1:0] PLOT_HEIGHT_RESET = 8'd100;

  // Reciprocal of three for a sum of three channels: floor(x/3) = (x*683) >> 11.
  localparam int SUM_W      = CHAN_W + 2;
  localparam int RECIP3     = 683;
  localparam int RECIP3_SH  = 11;
  localparam int RECIP3_W   = SUM_W + 10;

  // Stage-one command flags passed along with the item.
  typedef struct packed {
    logic accum;
    logic read;
  } s1_ctl_t;

endpackage

/* hw/rtl/rgb_histogram_bar_chart_top.sv */
// Accumulate and clear items are taken one per cycle while no read item holds off the input; a
// count lands in the store at the next edge. A read item holds off the input until its result
// is put out, longer while that result waits on the receiver. The result passes through the
// count store's read port, one multiply and an 8-step restoring divider.
// Reset is synchronous and active low: the per-bin valid bits, the peak and the configuration
// return to their defaults at once, so the whole store reads as zero with no clearing pass.
// A clear item empties the store the same way, with no clearing pass.
module rgb_histogram_bar_chart_top #(
  parameter int COUNT_WIDTH = rgbh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_command,
  input  logic [rgbh_pkg::CHAN_W-1:0]      in_red,
  input  logic [rgbh_pkg::CHAN_W-1:0]      in_green,
  input  logic [rgbh_pkg::CHAN_W-1:0]      in_blue,
  input  logic [rgbh_pkg::BIN_W-1:0]       in_query_bin,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rgbh_pkg::BIN_W-1:0]       out_bin_index,
  output logic [rgbh_pkg::OUT_CNT_W-1:0]   out_bin_count,
  output logic [rgbh_pkg::HEIGHT_W-1:0]    out_bar_height,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rgbh_pkg::ADDR_W-1:0]      paddr,
  input  logic [rgbh_pkg::APB_W-1:0]       pwdata,
  output logic [rgbh_pkg::APB_W-1:0]       prdata,
  output logic                             pready
);
  import rgbh_pkg::*;

  localparam int PROD_W = COUNT_WIDTH + HEIGHT_W;
  localparam int EXT_W  = COUNT_WIDTH + OUT_CNT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam int QBITS  = HEIGHT_W;
  localparam int STEP_W = $clog2(QBITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QBITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  // Configuration registers.
  logic [1:0]          bin_source_r;
  logic [HEIGHT_W-1:0] plot_height_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_source_r  <= SRC_GRAY;
      plot_height_r <= PLOT_HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_BIN_SOURCE) begin
        bin_source_r <= pwdata[1:0];
      end else begin
        plot_height_r <= pwdata[HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_PLOT_HEIGHT) begin
      prdata = APB_W'(plot_height_r);
    end else begin
      prdata = APB_W'(bin_source_r);
    end
  end

  // Input handshake and bin selection.
  state_t                  state_r;
  s1_ctl_t                 s1_ctl_r;
  logic                    in_acc;
  logic                    clr_acc;
  logic [SUM_W-1:0]        chan_sum;
  logic [RECIP3_W-1:0]     gray_prod;
  logic [BIN_W-1:0]        sel_bin;
  logic [BIN_W-1:0]        rd_addr;

  assign in_stall = (state_r != ST_IDLE) || s1_ctl_r.read;
  assign in_acc   = in_valid && !in_stall;
  assign clr_acc  = in_acc && (in_command == CMD_CLEAR);

  assign chan_sum  = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
  assign gray_prod = RECIP3_W'(chan_sum) * RECIP3_W'(RECIP3);

  always_comb begin
    unique case (bin_source_r)
      SRC_RED:   sel_bin = in_red;
      SRC_GREEN: sel_bin = in_green;
      SRC_BLUE:  sel_bin = in_blue;
      default:   sel_bin = gray_prod[RECIP3_SH +: BIN_W];
    endcase
  end

  assign rd_addr = (in_command == CMD_READ) ? in_query_bin : sel_bin;

  // Stage one holds the item whose store read is in flight.
  logic [BIN_W-1:0] s1_bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r.accum <= in_acc && (in_command == CMD_ACCUM);
      s1_ctl_r.read  <= in_acc && (in_command == CMD_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bin_r <= rd_addr;
    end
  end

  // Count store with one read port and one write port.
  logic [COUNT_WIDTH-1:0] count_mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic [NUM_BINS-1:0]    bin_vld_r;
  logic                   rvld_r;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      count_mem[s1_bin_r] <= wr_data;
    end
    rdata_r <= count_mem[rd_addr];
  end

  // Valid bits: an entry never written since reset or clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      rvld_r <= bin_vld_r[rd_addr];
      if (clr_acc) begin
        bin_vld_r <= '0;
      end else if (wr_en) begin
        bin_vld_r[s1_bin_r] <= 1'b1;
      end
    end
  end

  // Forward a write that lands on the entry being read in the same cycle.
  logic                   fwd_hit_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else begin
      fwd_hit_r <= wr_en && (s1_bin_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

  // Stage one: current count, saturating increment and peak update.
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] peak_r;

  always_comb begin
    if (fwd_hit_r) begin
      cur_cnt = fwd_data_r;
    end else if (rvld_r) begin
      cur_cnt = rdata_r;
    end else begin
      cur_cnt = '0;
    end
  end

  assign wr_en   = s1_ctl_r.accum && (cur_cnt != COUNT_MAX);
  assign wr_data = cur_cnt + COUNT_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (clr_acc) begin
      peak_r <= '0;
    end else if (wr_en && (wr_data > peak_r)) begin
      peak_r <= wr_data;
    end
  end

  // Read path: multiply, then a restoring divider producing one quotient bit a cycle.
  logic [PROD_W-1:0]   rem_r;
  logic [PROD_W-1:0]   dsr_r;
  logic [QBITS-1:0]    quo_r;
  logic [STEP_W-1:0]   step_r;
  logic                pzero_r;
  logic [BIN_W-1:0]    res_bin_r;
  logic [COUNT_WIDTH-1:0] res_cnt_r;
  logic                out_valid_r;
  logic [BIN_W-1:0]    out_bin_r;
  logic [OUT_CNT_W-1:0] out_cnt_r;
  logic [HEIGHT_W-1:0] out_height_r;
  logic                rem_ge;
  logic [EXT_W-1:0]    cnt_ext;

  assign rem_ge  = rem_r >= dsr_r;
  assign cnt_ext = EXT_W'(res_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      // A new result in the done state replaces the one taken, so only clear it otherwise.
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (s1_ctl_r.read) begin
            rem_r     <= PROD_W'(cur_cnt) * PROD_W'(plot_height_r);
            dsr_r     <= PROD_W'(peak_r) << (QBITS - 1);
            pzero_r   <= (peak_r == '0);
            res_bin_r <= s1_bin_r;
            res_cnt_r <= cur_cnt;
            quo_r     <= '0;
            step_r    <= '0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_r <= rem_r - dsr_r;
          end
          quo_r  <= {quo_r[QBITS-2:0], rem_ge};
          dsr_r  <= dsr_r >> 1;
          step_r <= step_r + STEP_W'(1);
          if (step_r == LAST_STEP) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_bin_r    <= res_bin_r;
            out_cnt_r    <= cnt_ext[OUT_CNT_W-1:0];
            out_height_r <= pzero_r ? '0 : quo_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_index  = out_bin_r;
  assign out_bin_count  = out_cnt_r;
  assign out_bar_height = out_height_r;

`ifndef SYNTH
  // A bin's height never exceeds the plot height, since no count exceeds the peak.
  a_height_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !pzero_r) |-> (quo_r <= plot_height_r))
    else $error("bar height above plot height");

  // The peak covers every count just written, unless a clear came in.
  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !clr_acc) |=> (peak_r >= $past(wr_data)))
    else $error("peak below a written count");

  // A taken read item holds off the next item while its result is built.
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command == CMD_READ) |=> (in_stall && !wr_en))
    else $error("input not held during read");

  // A forwarded count only follows a write in the cycle before.
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> $past(wr_en))
    else $error("forward without a write");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rgbh_pkg::*;

  // Command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] ADDR_BIN_SOURCE  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_PLOT_HEIGHT = 3'd4;

  localparam logic [OUT_CNT_W-1:0] COUNT_FULL = '1;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS    = 320;

  // One expected bar readout.
  typedef struct packed {
    logic [BIN_W-1:0]     bin;
    logic [OUT_CNT_W-1:0] count;
    logic [HEIGHT_W-1:0]  height;
  } bar_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_command;
  logic [CHAN_W-1:0]    in_red;
  logic [CHAN_W-1:0]    in_green;
  logic [CHAN_W-1:0]    in_blue;
  logic [BIN_W-1:0]     in_query_bin;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BIN_W-1:0]     out_bin_index;
  logic [OUT_CNT_W-1:0] out_bin_count;
  logic [HEIGHT_W-1:0]  out_bar_height;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [APB_W-1:0]     pwdata;
  logic [APB_W-1:0]     prdata;
  logic                 pready;

  // Histogram predictor state and configuration.
  logic [OUT_CNT_W-1:0] bin_tally [NUM_BINS];
  logic [OUT_CNT_W-1:0] tally_peak;
  logic [1:0]           src_sel;
  logic [HEIGHT_W-1:0]  bar_scale;
  bar_t                 pending_bars [$];

  // Stimulus shaping.
  logic [7:0] hot_level [4];
  logic [7:0] last_bin;
  bit         sender_quiet;
  bit         receiver_quiet;
  bit         hold_request;

  // Bookkeeping.
  int errors;
  int n_accum;
  int n_read;
  int n_clear;
  int n_unused;
  int n_checked;
  int n_settings;
  logic [OUT_CNT_W-1:0] max_peak;

  rgb_histogram_bar_chart_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_query_bin  (in_query_bin),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bin_index (out_bin_index),
    .out_bin_count (out_bin_count),
    .out_bar_height(out_bar_height),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle length: mostly short, now and then a long one.
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Send one item, then update the predictor once the block has taken it.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] q);
    int gap;
    int i;
    logic [7:0]  bin;
    logic [9:0]  sum;
    logic [31:0] prod;
    bar_t        bar;
    gap = (sender_quiet || $urandom_range(0, 99) < 55) ? 0 : idle_span();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    in_query_bin <= q;
    do @(posedge clk); while (in_stall);

    case (cmd)
      CMD_ACCUM: begin
        sum = 10'(r) + 10'(g) + 10'(b);
        case (src_sel)
          SRC_RED:   bin = r;
          SRC_GREEN: bin = g;
          SRC_BLUE:  bin = b;
          default:   bin = 8'(sum / 10'd3);
        endcase
        // A full bin stays put, and so does the peak.
        if (bin_tally[bin] != COUNT_FULL) begin
          bin_tally[bin] = bin_tally[bin] + 1'b1;
          if (bin_tally[bin] > tally_peak) begin
            tally_peak = bin_tally[bin];
          end
        end
        if (tally_peak > max_peak) begin
          max_peak = tally_peak;
        end
        last_bin = bin;
        n_accum++;
      end
      CMD_READ: begin
        bar.bin   = q;
        bar.count = bin_tally[q];
        prod      = 32'(bin_tally[q]) * 32'(bar_scale);
        // An empty histogram has no peak to scale by, so the bar is flat.
        bar.height = (tally_peak == '0) ? '0 : 8'(prod / 32'(tally_peak));
        pending_bars.push_back(bar);
        n_read++;
      end
      CMD_CLEAR: begin
        for (i = 0; i < NUM_BINS; i++) begin
          bin_tally[i] = '0;
        end
        tally_peak = '0;
        n_clear++;
      end
      default: n_unused++;
    endcase
  endtask

  // Drop valid after the last item of a sequence.
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every readout is back and in-flight counts have landed.
  task automatic wait_idle();
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_reg(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata mismatch at address %0d: expected %0d, actual %0d", addr, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register, mirror it in the predictor and read it back.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
    logic [APB_W-1:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_BIN_SOURCE) begin
      src_sel = data[1:0];
      want    = APB_W'(data[1:0]);
    end else begin
      bar_scale = data[7:0];
      want      = APB_W'(data[7:0]);
    end
    read_reg(addr, want);
  endtask

  // One random item: mostly accumulates, reads aimed mostly at bins that hold counts.
  task automatic random_item();
    int pick;
    int shade;
    logic [1:0] cmd;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] q;
    pick = $urandom_range(0, 199);
    if (pick < 140) begin
      cmd = CMD_ACCUM;
    end else if (pick < 190) begin
      cmd = CMD_READ;
    end else if (pick < 194) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = CMD_UNUSED;
    end
    shade = $urandom_range(0, 99);
    if (shade < 45) begin
      r = hot_level[$urandom_range(0, 3)];
      g = r;
      b = r;
    end else if (shade < 55) begin
      r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
    end
    shade = $urandom_range(0, 99);
    if (shade < 50) begin
      q = last_bin;
    end else if (shade < 75) begin
      q = hot_level[$urandom_range(0, 3)];
    end else begin
      q = 8'($urandom);
    end
    send_item(cmd, r, g, b, q);
  endtask

  // Defaults after reset and readouts of an empty histogram.
  task automatic test_reset_state();
    read_reg(ADDR_BIN_SOURCE, APB_W'(SRC_GRAY));
    read_reg(ADDR_PLOT_HEIGHT, APB_W'(PLOT_HEIGHT_RESET));
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'd255);
    release_input();
    wait_idle();
  endtask

  // Channel extremes in gray mode, the ignored command, clear and a zero peak.
  task automatic test_directed();
    send_item(CMD_ACCUM, 8'd0, 8'd0, 8'd0, 8'hFF);
    send_item(CMD_ACCUM, 8'd255, 8'd255, 8'd255, 8'h00);
    send_item(CMD_ACCUM, 8'd255, 8'd255, 8'd255, 8'h00);
    send_item(CMD_ACCUM, 8'd255, 8'd254, 8'd255, 8'h00);
    send_item(CMD_ACCUM, 8'd1, 8'd1, 8'd0, 8'h00);
    send_item(CMD_ACCUM, 8'd128, 8'd0, 8'd255, 8'h00);
    send_item(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'd255);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd254);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd127);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd200);
    send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd255);
    send_item(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd255);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd0);
    send_item(CMD_ACCUM, 8'd85, 8'd85, 8'd85, 8'h00);
    send_item(CMD_READ, 8'h00, 8'h00, 8'h00, 8'd85);
    release_input();
    wait_idle();
  endtask

  // A block of random items under one register setting.
  task automatic test_random_phase(input logic [1:0] src, input logic [7:0] height);
    int k;
    write_reg(ADDR_BIN_SOURCE, APB_W'(src));
    write_reg(ADDR_PLOT_HEIGHT, APB_W'(height));
    n_settings++;
    foreach (hot_level[i]) hot_level[i] = 8'($urandom);
    for (k = 0; k < PHASE_ITEMS; k++) begin
      // The second quarter runs with no idling on either side.
      sender_quiet   = (k >= PHASE_ITEMS / 4) && (k < PHASE_ITEMS / 2);
      receiver_quiet = sender_quiet;
      random_item();
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
    release_input();
    wait_idle();
  endtask

  // The receiver holds off while reads keep coming, so the block backs up.
  task automatic test_backpressure();
    int k;
    sender_quiet = 1'b1;
    @(posedge clk);
    hold_request = 1'b1;
    for (k = 0; k < 60; k++) begin
      if ($urandom_range(0, 99) < 70) begin
        send_item(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), last_bin);
      end else begin
        send_item(CMD_ACCUM, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    sender_quiet = 1'b0;
    release_input();
    wait_idle();
  endtask

  // Receiver stall pattern, including the long hold that a test asks for.
  always @(negedge clk) begin : drive_stall
    int hold_left;
    int stall_run;
    bit stall_on;
    bit hold_seen;
    if (hold_request && !hold_seen) begin
      hold_left = HOLD_CYCLES;
    end
    hold_seen = hold_request;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (receiver_quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run <= 0) begin
        stall_on  = ($urandom_range(0, 99) < 30);
        stall_run = idle_span();
      end
      stall_run--;
      out_stall <= stall_on;
    end
  end

  // Compare each bar readout with the oldest one predicted.
  always @(posedge clk) begin : check_bars
    bar_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bars.size() == 0) begin
        $error("readout of bin %0d with no read item waiting", out_bin_index);
        errors++;
      end else begin
        want = pending_bars.pop_front();
        n_checked++;
        if (out_bin_index !== want.bin) begin
          $error("bin_index mismatch: expected %0d, actual %0d", want.bin, out_bin_index);
          errors++;
        end
        if (out_bin_count !== want.count) begin
          $error("bin_count mismatch: expected %0d, actual %0d", want.count, out_bin_count);
          errors++;
        end
        if (out_bar_height !== want.height) begin
          $error("bar_height mismatch: expected %0d, actual %0d", want.height,
                 out_bar_height);
          errors++;
        end
      end
    end
  end

  // End the run if nothing moves on any port for too long.
  always @(posedge clk) begin : watchdog
    int quiet_cycles;
    if (!rst_n || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake in %0d cycles, %0d readouts outstanding",
               WATCHDOG_LIMIT, pending_bars.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_command   = CMD_ACCUM;
    in_red       = '0;
    in_green     = '0;
    in_blue      = '0;
    in_query_bin = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    tally_peak   = '0;
    src_sel      = SRC_GRAY;
    bar_scale    = PLOT_HEIGHT_RESET;
    foreach (hot_level[i]) hot_level[i] = '0;
    last_bin     = '0;
    max_peak     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed();
    test_random_phase(SRC_GRAY, 8'd100);
    test_random_phase(SRC_RED, 8'd255);
    test_random_phase(SRC_GREEN, 8'd1);
    test_random_phase(SRC_BLUE, 8'd0);
    test_random_phase(SRC_GRAY, 8'd37);
    test_backpressure();

    while (pending_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d accumulates, %0d reads, %0d clears and %0d ignored commands",
             n_accum, n_read, n_clear, n_unused);
    $display("over %0d register settings; %0d readouts checked, highest peak %0d.",
             n_settings, n_checked, max_peak);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
